// ----- hw/rtl/rans_symbol_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// rANS symbol decoder assertion macros
// Shared concurrent assertion forms for the decoder core.
// ----------------------------------------------------------------------------
`ifndef RANS_SYMBOL_DECODER_CORE_MACROS_SVH
`define RANS_SYMBOL_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define RSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsd assertion failed");

// next-cycle implication
`define RSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsd assertion failed");

`endif

// ----- hw/rtl/rsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg
// Types, codes and default sizes for the rANS symbol decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

	localparam int DEF_MAX_PRECISION = 16;
	localparam int DEF_BLOCK_BYTES   = 4096;

	localparam int CMD_W   = 3;
	localparam int IDX_W   = 16;
	localparam int SYM_W   = 8;
	localparam int FREQ_W  = 17;
	localparam int CUM_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int STAT_W  = 2;
	localparam int PREC_W  = 5;
	localparam int STATE_W = 32;

	localparam logic [PREC_W-1:0] PREC_RESET = 5'd16;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DECODE = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_CORRUPT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

	typedef struct packed {
		logic [SYM_W-1:0]  symbol;
		logic [FREQ_W-1:0] freq;
		logic [CUM_W-1:0]  cum;
	} slot_entry_t;

endpackage

// ----- hw/rtl/rsd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_if
// Command, result and configuration channels of the rANS symbol decoder.
// ----------------------------------------------------------------------------
interface rsd_req_if import rsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [IDX_W-1:0]  slot_index;
	logic [SYM_W-1:0]  entry_symbol;
	logic [FREQ_W-1:0] entry_frequency;
	logic [CUM_W-1:0]  entry_cumulative;
	logic [BYTE_W-1:0] block_byte;

	modport source (output valid, command, slot_index, entry_symbol, entry_frequency,
		entry_cumulative, block_byte, input ready);
	modport sink (input valid, command, slot_index, entry_symbol, entry_frequency,
		entry_cumulative, block_byte, output ready);
endinterface

interface rsd_rsp_if import rsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SYM_W-1:0]  decoded_symbol;
	logic [STAT_W-1:0] status;

	modport source (output valid, decoded_symbol, status, input ready);
	modport sink (input valid, decoded_symbol, status, output ready);
endinterface

interface rsd_cfg_if import rsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PREC_W-1:0] scale_log2;

	modport source (output valid, scale_log2, input ready);
	modport sink (input valid, scale_log2, output ready);
endinterface

// ----- hw/rtl/rsd_slot_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_slot_table
// Slot table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsd_slot_table
	import rsd_pkg::*;
#(
	parameter int ADDR_W = DEF_MAX_PRECISION
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  slot_entry_t       wr_entry,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output slot_entry_t       rd_entry
);

	slot_entry_t mem [2**ADDR_W];
	slot_entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule

// ----- hw/rtl/rans_symbol_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rans_symbol_decoder_core
// Command-driven rANS decoder with byte renormalization.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction: load a slot table entry, push a
//   block byte, clear the block, start the block or decode one symbol.
//   rsp returns exactly one transaction per command: decoded symbol (zero for
//   non-decode commands) and status (ok, corrupt stream, buffer full).
//   cfg writes scale_log2; write it only while no command is in flight.
// Sequence:
//   load, push, clear and unused commands go from S_EXEC to S_DONE. Start
//   reads the length byte in S_LEN, then folds state bytes in via S_FRD and
//   S_FOLD, ending early on a corrupt length or an empty block. Decode runs
//   S_MUL, S_ADD and S_RN, plus S_FOLD per renormalization byte (usually 0
//   to 2). One command at a time; req is ready again as rsp valid rises.
// Reset: arst_n clears block counters, coder state and precision (to 16).
//   Slot table and block buffer contents are undefined until written.
// Stall: a finished result is held in the rsp register; the next command is
//   accepted meanwhile and waits in its final state until rsp is taken.
// ----------------------------------------------------------------------------
`include "rans_symbol_decoder_core_macros.svh"

module rans_symbol_decoder_core
	import rsd_pkg::*;
#(
	parameter int MAX_PRECISION = DEF_MAX_PRECISION,
	parameter int BLOCK_BYTES   = DEF_BLOCK_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	rsd_req_if.sink   req,
	rsd_rsp_if.source rsp,
	rsd_cfg_if.sink   cfg
);

	localparam int AW    = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
	localparam int WCW   = $clog2(BLOCK_BYTES + 1);
	localparam int CMP_W = ((WCW > BYTE_W) ? WCW : BYTE_W) + 1;
	localparam int TW    = MAX_PRECISION;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_LEN  = 4'd2;
	localparam logic [3:0] S_FRD  = 4'd3;
	localparam logic [3:0] S_FOLD = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_ADD  = 4'd6;
	localparam logic [3:0] S_RN   = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]         state_q;
	logic [PREC_W-1:0]  prec_q;
	logic [WCW-1:0]     wc_q;
	logic [WCW-1:0]     rp_q;
	logic [STATE_W-1:0] x_q;
	logic [BYTE_W-1:0]  cnt_q;
	logic               rsp_valid_q;

	logic [CMD_W-1:0]   cmd_q;
	logic [TW-1:0]      idx_q;
	slot_entry_t        entry_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [SYM_W-1:0]   sym_q;
	logic [STAT_W-1:0]  stat_q;
	logic [STATE_W-1:0] prod_q;
	logic [TW-1:0]      slot_q;
	logic [CUM_W-1:0]   cum_q;
	logic [SYM_W-1:0]   rsp_sym_q;
	logic [STAT_W-1:0]  rsp_stat_q;

	logic [BYTE_W-1:0]  buf_mem [BLOCK_BYTES];
	logic [BYTE_W-1:0]  buf_rd_q;
	logic               buf_rd_en;
	logic [AW-1:0]      buf_rd_addr;
	logic               buf_wr_en;

	logic               tab_wr_en;
	logic               tab_rd_en;
	slot_entry_t        tab_rd_entry;

	logic [PREC_W-1:0]  p_eff;
	logic [TW-1:0]      slot_mask;
	logic [TW-1:0]      slot_addr;
	logic [30:0]        x_shr;
	logic [47:0]        prod_full;
	logic               below_bound;
	logic               bytes_left;
	logic               buf_has_room;
	logic               len_bad;
	logic               rsp_free;
	logic [STATE_W-1:0] fold_x;

	// effective precision and decode arithmetic
	always_comb begin
		if (prec_q == '0) begin
			p_eff = PREC_W'(1);
		end else if (prec_q > PREC_W'(MAX_PRECISION)) begin
			p_eff = PREC_W'(MAX_PRECISION);
		end else begin
			p_eff = prec_q;
		end
	end

	assign slot_mask    = TW'((33'(1) << p_eff) - 33'(1));
	assign slot_addr    = x_q[TW-1:0] & slot_mask;
	assign x_shr        = 31'(x_q >> p_eff);
	assign prod_full    = 48'(tab_rd_entry.freq) * 48'(x_shr);
	assign below_bound  = {1'b0, x_q} < (33'(1) << (p_eff + PREC_W'(8)));
	assign bytes_left   = rp_q < wc_q;
	assign buf_has_room = wc_q < WCW'(BLOCK_BYTES);
	assign len_bad      = (CMP_W'(buf_rd_q) + CMP_W'(1)) > CMP_W'(wc_q);
	assign rsp_free     = !rsp_valid_q || rsp.ready;
	assign fold_x       = {x_q[STATE_W-BYTE_W-1:0], buf_rd_q};

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.decoded_symbol = rsp_sym_q;
	assign rsp.status         = rsp_stat_q;

	// memory port controls
	assign tab_wr_en   = (state_q == S_EXEC) && (cmd_q == CMD_LOAD);
	assign tab_rd_en   = (state_q == S_EXEC) && (cmd_q == CMD_DECODE);
	assign buf_wr_en   = (state_q == S_EXEC) && (cmd_q == CMD_PUSH) && buf_has_room;
	assign buf_rd_addr = (state_q == S_EXEC) ? '0 : rp_q[AW-1:0];

	always_comb begin
		unique case (state_q)
			S_EXEC:  buf_rd_en = (cmd_q == CMD_START) && (wc_q != '0);
			S_FRD:   buf_rd_en = (cnt_q != '0);
			S_RN:    buf_rd_en = below_bound && bytes_left;
			default: buf_rd_en = 1'b0;
		endcase
	end

	rsd_slot_table #(
		.ADDR_W (TW)
	) u_slot_table (
		.clk      (clk),
		.wr_en    (tab_wr_en),
		.wr_addr  (idx_q),
		.wr_entry (entry_q),
		.rd_en    (tab_rd_en),
		.rd_addr  (slot_addr),
		.rd_entry (tab_rd_entry)
	);

	always_ff @(posedge clk) begin
		if (buf_wr_en) begin
			buf_mem[wc_q[AW-1:0]] <= byte_q;
		end
		if (buf_rd_en) begin
			buf_rd_q <= buf_mem[buf_rd_addr];
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prec_q      <= PREC_RESET;
			wc_q        <= '0;
			rp_q        <= '0;
			x_q         <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				prec_q <= cfg.scale_log2;
			end
			if ((state_q == S_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q)
						CMD_PUSH: begin
							if (buf_has_room) begin
								wc_q <= wc_q + WCW'(1);
							end
							state_q <= S_DONE;
						end
						CMD_CLEAR: begin
							wc_q    <= '0;
							rp_q    <= '0;
							state_q <= S_DONE;
						end
						CMD_START: begin
							if (wc_q == '0) begin
								x_q     <= '0;
								rp_q    <= '0;
								state_q <= S_DONE;
							end else begin
								state_q <= S_LEN;
							end
						end
						CMD_DECODE: state_q <= S_MUL;
						default:    state_q <= S_DONE;
					endcase
				end
				S_LEN: begin
					if (len_bad) begin
						state_q <= S_DONE;
					end else begin
						x_q     <= '0;
						rp_q    <= WCW'(1);
						cnt_q   <= buf_rd_q;
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					state_q <= (cnt_q != '0) ? S_FOLD : S_DONE;
				end
				S_FOLD: begin
					x_q     <= fold_x;
					rp_q    <= rp_q + WCW'(1);
					cnt_q   <= cnt_q - BYTE_W'(1);
					state_q <= (cmd_q == CMD_START) ? S_FRD : S_RN;
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					x_q     <= prod_q + STATE_W'(slot_q) - STATE_W'(cum_q);
					state_q <= S_RN;
				end
				S_RN: begin
					state_q <= (below_bound && bytes_left) ? S_FOLD : S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q          <= req.command;
			idx_q          <= req.slot_index[TW-1:0];
			entry_q.symbol <= req.entry_symbol;
			entry_q.freq   <= req.entry_frequency;
			entry_q.cum    <= req.entry_cumulative;
			byte_q         <= req.block_byte;
		end
		if (state_q == S_EXEC) begin
			sym_q  <= '0;
			stat_q <= (cmd_q == CMD_PUSH && !buf_has_room) ? STAT_FULL : STAT_OK;
			slot_q <= slot_addr;
		end
		if (state_q == S_LEN && len_bad) begin
			stat_q <= STAT_CORRUPT;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_full[STATE_W-1:0];
			cum_q  <= tab_rd_entry.cum;
			sym_q  <= tab_rd_entry.symbol;
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_sym_q  <= sym_q;
			rsp_stat_q <= stat_q;
		end
	end

	`RSD_ASSERT_NOW(a_wc_bound, clk, arst_n, 1'b1, wc_q <= WCW'(BLOCK_BYTES))
	`RSD_ASSERT_NOW(a_rp_le_wc, clk, arst_n, 1'b1, rp_q <= wc_q)
	`RSD_ASSERT_NEXT(a_done_rsp, clk, arst_n, (state_q == S_DONE) && rsp_free, rsp_valid_q)

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rANS symbol decoder core. Commands go in over
// the req channel and a built-in predictor keeps the slot table, the block
// buffer and the coder state, so each rsp transaction is checked in order.
// A directed opener hits the field extremes, the empty and corrupt block
// cases and the unused commands. Random blocks and command noise then follow
// over several precision settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import rsd_pkg::*;

	localparam int TABLE_DEPTH = 1 << DEF_MAX_PRECISION;
	localparam int BLOCK_BYTES = DEF_BLOCK_BYTES;
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_DECODE + 1'b1;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;
	localparam int CYCLE_LIMIT      = 1000000;
	localparam int HOLD_AT          = 40;
	localparam int HOLD_CYCLES      = 400;
	localparam int PRINT_CAP        = 40;
	localparam int TAIL_CYCLES      = 20;
	localparam int IDLE_CYCLES      = 4;
	localparam int CONSISTENT_MAX_P = 6;
	localparam int ITEMS_PER_HALF   = 60;

	typedef struct packed {
		bit [CMD_W-1:0]  command;
		bit [IDX_W-1:0]  slot_index;
		bit [SYM_W-1:0]  entry_symbol;
		bit [FREQ_W-1:0] entry_frequency;
		bit [CUM_W-1:0]  entry_cumulative;
		bit [BYTE_W-1:0] block_byte;
	} rsd_cmd_t;

	typedef struct packed {
		logic [SYM_W-1:0]  symbol;
		logic [STAT_W-1:0] status;
	} rsd_result_t;

	class rans_scoreboard;
		bit [SYM_W-1:0]   slot_symbol [TABLE_DEPTH];
		bit [FREQ_W-1:0]  slot_freq [TABLE_DEPTH];
		bit [CUM_W-1:0]   slot_cum [TABLE_DEPTH];
		bit               slot_loaded [TABLE_DEPTH];
		bit [BYTE_W-1:0]  block_mem [BLOCK_BYTES];
		int unsigned      fill_count;
		int unsigned      read_pos;
		bit [STATE_W-1:0] rans_state;
		bit [PREC_W-1:0]  precision;
		rsd_result_t      expected_results [$];
		int unsigned      mismatches, checked, decodes, full_hits, corrupt_hits, cfg_writes;

		function new();
			precision = PREC_RESET;
			fill_count = 0;
			read_pos = 0;
			rans_state = '0;
		endfunction

		function int unsigned eff_precision();
			int unsigned p;
			p = precision;
			if (p == 0)
				p = 1;
			if (p > DEF_MAX_PRECISION)
				p = DEF_MAX_PRECISION;
			return p;
		endfunction

		function bit [IDX_W-1:0] next_slot();
			return IDX_W'(rans_state & ((32'd1 << eff_precision()) - 32'd1));
		endfunction

		function void note_precision(input bit [PREC_W-1:0] v);
			precision = v;
			cfg_writes++;
		endfunction

		function void note_command(input rsd_cmd_t c);
			rsd_result_t      r;
			int unsigned      p, len;
			bit [IDX_W-1:0]   slot;
			bit [63:0]        prod;
			bit [STATE_W-1:0] acc;
			r = '0;
			case (c.command)
			CMD_LOAD: begin
				slot_symbol[c.slot_index] = c.entry_symbol;
				slot_freq[c.slot_index] = c.entry_frequency;
				slot_cum[c.slot_index] = c.entry_cumulative;
				slot_loaded[c.slot_index] = 1'b1;
			end
			CMD_PUSH: begin
				if (fill_count < BLOCK_BYTES) begin
					block_mem[fill_count] = c.block_byte;
					fill_count++;
				end else begin
					r.status = STAT_FULL;
					full_hits++;
				end
			end
			CMD_CLEAR: begin
				fill_count = 0;
				read_pos = 0;
			end
			CMD_START: begin
				if (fill_count == 0) begin
					rans_state = '0;
					read_pos = 0;
				end else begin
					len = block_mem[0];
					if (1 + len > fill_count) begin
						r.status = STAT_CORRUPT;
						corrupt_hits++;
					end else begin
						acc = '0;
						for (int i = 0; i < len; i++)
							acc = {acc[STATE_W-9:0], block_mem[1 + i]};
						rans_state = acc;
						read_pos = 1 + len;
					end
				end
			end
			CMD_DECODE: begin
				p = eff_precision();
				slot = next_slot();
				prod = 64'(slot_freq[slot]) * 64'(rans_state >> p);
				acc = STATE_W'(prod + 64'(slot) - 64'(slot_cum[slot]));
				while (acc < (32'd1 << (p + 8)) && read_pos < fill_count
					&& read_pos < BLOCK_BYTES) begin
					acc = {acc[STATE_W-9:0], block_mem[read_pos]};
					read_pos++;
				end
				rans_state = acc;
				r.symbol = slot_symbol[slot];
				decodes++;
			end
			default: ;
			endcase
			expected_results.push_back(r);
		endfunction

		function void check_result(input rsd_result_t got);
			rsd_result_t want;
			if (expected_results.size() == 0) begin
				if (mismatches < PRINT_CAP)
					$display("%0t: result with none outstanding: symbol %0h status %0d",
						$time, got.symbol, got.status);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (got.symbol !== want.symbol) begin
				if (mismatches < PRINT_CAP)
					$display("%0t: decoded_symbol expected %0h actual %0h",
						$time, want.symbol, got.symbol);
				mismatches++;
			end
			if (got.status !== want.status) begin
				if (mismatches < PRINT_CAP)
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rsd_req_if req();
	rsd_rsp_if rsp();
	rsd_cfg_if cfg();

	rans_symbol_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	rans_scoreboard sb = new();
	int unsigned    sender_idle_pct = 0;
	int unsigned    receiver_stall_pct = 0;
	int unsigned    items_counted = 0;
	int unsigned    n_results = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit [FREQ_W-1:0] random_freq();
		case ($urandom_range(5))
		0: return '0;
		1: return FREQ_W'(1);
		2: return FREQ_W'(1 << DEF_MAX_PRECISION);
		3: return '1;
		4: return FREQ_W'($urandom_range(256, 1));
		default: return FREQ_W'($urandom);
		endcase
	endfunction

	function automatic rsd_cmd_t random_payload(input bit [CMD_W-1:0] op);
		rsd_cmd_t c;
		c.command = op;
		c.slot_index = IDX_W'($urandom);
		c.entry_symbol = SYM_W'($urandom);
		c.entry_frequency = random_freq();
		c.entry_cumulative = CUM_W'($urandom);
		c.block_byte = BYTE_W'($urandom);
		return c;
	endfunction

	task automatic send(input rsd_cmd_t c);
		while ($urandom_range(99) < sender_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= c.command;
		req.slot_index <= c.slot_index;
		req.entry_symbol <= c.entry_symbol;
		req.entry_frequency <= c.entry_frequency;
		req.entry_cumulative <= c.entry_cumulative;
		req.block_byte <= c.block_byte;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_command(c);
		if (c.command <= CMD_DECODE)
			items_counted++;
	endtask

	task automatic load_slot(input int unsigned idx, input int unsigned sym,
		input bit [FREQ_W-1:0] f, input int unsigned cum);
		rsd_cmd_t c;
		c = random_payload(CMD_LOAD);
		c.slot_index = IDX_W'(idx);
		c.entry_symbol = SYM_W'(sym);
		c.entry_frequency = f;
		c.entry_cumulative = CUM_W'(cum);
		send(c);
	endtask

	task automatic push_byte(input bit [BYTE_W-1:0] b);
		rsd_cmd_t c;
		c = random_payload(CMD_PUSH);
		c.block_byte = b;
		send(c);
	endtask

	// load the slot the next decode will read if it was never written
	task automatic decode_one();
		bit [IDX_W-1:0] slot;
		slot = sb.next_slot();
		if (!sb.slot_loaded[slot])
			load_slot(slot, $urandom, random_freq(), $urandom);
		send(random_payload(CMD_DECODE));
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_precision(input bit [PREC_W-1:0] v);
		wait_idle();
		cfg.valid <= 1'b1;
		cfg.scale_log2 <= v;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		sb.note_precision(v);
	endtask

	// split 2^p slots among a few symbols with matching frequency and cumulative
	task automatic build_table(input int unsigned p);
		int unsigned    total, nsym, f, base;
		bit [SYM_W-1:0] sym;
		total = 1 << p;
		nsym = $urandom_range(1, (total < 6) ? total : 6);
		base = 0;
		for (int s = 0; s < nsym; s++) begin
			f = (s == nsym - 1) ? total - base
				: $urandom_range(1, total - base - (nsym - 1 - s));
			sym = SYM_W'($urandom);
			for (int k = 0; k < f; k++)
				load_slot(base + k, sym, FREQ_W'(f), base);
			base += f;
		end
	endtask

	initial begin : rsp_sink
		int unsigned hold_left;
		bit          hold_done;
		rsd_result_t got;
		hold_left = 0;
		hold_done = 1'b0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got.symbol = rsp.decoded_symbol;
				got.status = rsp.status;
				sb.check_result(got);
				n_results++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (!hold_done && n_results >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		bit [PREC_W-1:0] plan [8];
		int unsigned     r, len, body, target;
		rsd_cmd_t        c;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.command <= CMD_LOAD;
		req.slot_index <= '0;
		req.entry_symbol <= '0;
		req.entry_frequency <= '0;
		req.entry_cumulative <= '0;
		req.block_byte <= '0;
		cfg.valid <= 1'b0;
		cfg.scale_log2 <= PREC_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opener at reset precision
		load_slot(16'hFFFF, 8'hFF, FREQ_W'(1 << DEF_MAX_PRECISION), 16'hFFFF);
		load_slot(0, 0, '0, 0);
		decode_one();
		send(random_payload(CMD_START));
		push_byte(8'd5);
		push_byte(8'hAA);
		push_byte(8'h55);
		send(random_payload(CMD_START));
		send(random_payload(CMD_CLEAR));
		push_byte(8'd2);
		push_byte(8'hFF);
		push_byte(8'hFF);
		send(random_payload(CMD_START));
		decode_one();
		push_byte(8'h12);
		push_byte(8'h34);
		decode_one();
		decode_one();
		send(random_payload(CMD_SPARE_FIRST));
		send(random_payload(CMD_SPARE_LAST));
		load_slot(16'h00A5, 8'h5A, '1, 16'h8000);
		send(random_payload(CMD_CLEAR));
		push_byte(8'd0);
		send(random_payload(CMD_START));
		decode_one();

		write_precision('1);

		// longest length byte: one byte short, then exact
		send(random_payload(CMD_CLEAR));
		push_byte(8'd255);
		repeat (254) push_byte($urandom);
		send(random_payload(CMD_START));
		push_byte($urandom);
		send(random_payload(CMD_START));
		repeat (8) decode_one();

		plan = '{5'd0, 5'd1, 5'd16, 5'd4, 5'd3, 5'd8, 5'd2, 5'd12};
		plan[7] = PREC_W'($urandom_range(15, 5));
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			sender_idle_pct = (ph == 1) ? 63 : (ph == 3) ? 31 : 0;
			receiver_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 31 : 0;
			for (int h = 0; h < 2; h++) begin
				write_precision(plan[2 * ph + h]);
				if (sb.eff_precision() <= CONSISTENT_MAX_P)
					build_table(sb.eff_precision());
				target = items_counted + ITEMS_PER_HALF;
				while (items_counted < target) begin
					r = $urandom_range(99);
					if (r < 55) begin
						len = ($urandom_range(9) == 0) ? $urandom_range(12, 0)
							: $urandom_range(4, 1);
						body = len + $urandom_range(16, 0);
						if (len > 0 && $urandom_range(9) == 0)
							body = $urandom_range(len - 1, 0);
						send(random_payload(CMD_CLEAR));
						push_byte(BYTE_W'(len));
						repeat (body) push_byte($urandom);
						send(random_payload(CMD_START));
						repeat ($urandom_range(20, 1)) decode_one();
					end else if (r < 72) begin
						decode_one();
					end else if (r < 82) begin
						push_byte($urandom);
					end else if (r < 88) begin
						load_slot($urandom, $urandom, random_freq(), $urandom);
					end else if (r < 93) begin
						send(random_payload(CMD_START));
					end else if (r < 97) begin
						send(random_payload(CMD_CLEAR));
					end else begin
						c = random_payload(CMD_SPARE_FIRST);
						c.command = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
						send(c);
					end
				end
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d commands with %0d decodes; %0d results checked, %0d mismatches",
			items_counted, sb.decodes, sb.checked, sb.mismatches);
		$display("Saw %0d buffer-full and %0d corrupt-length results over %0d precision writes",
			sb.full_hits, sb.corrupt_hits, sb.cfg_writes);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rsd_pkg.sv
hw/rtl/rsd_if.sv
hw/rtl/rsd_slot_table.sv
hw/rtl/rans_symbol_decoder_core.sv
verif/tb_top.sv
